// ----- src/brd_pkg.sv -----
// Shared types and constants for the bitstream reader.
// Holds the operation codes, the payload structs and the command record
// passed from the front end through the command queue to the back end.
package brd_pkg;

  localparam int COUNT_W = 13;
  localparam int CUR_W   = 14;
  localparam int BITS_W  = 6;
  localparam int BURST_W = 7;
  localparam int LADDR_W = 12;
  localparam int VALUE_W = 32;

  localparam int DEFAULT_BUF_DEPTH = 4096;
  localparam int DEFAULT_MAX_BITS  = 32;
  localparam int DEFAULT_MAX_BURST = 64;

  localparam logic [2:0] TOP_BIT = 3'd7;

  typedef enum logic [2:0] {
    OP_LOAD     = 3'd0,
    OP_REWIND   = 3'd1,
    OP_BITS_MSB = 3'd2,
    OP_BITS_LSB = 3'd3,
    OP_BYTES    = 3'd4,
    OP_SKIP     = 3'd5,
    OP_PEEK     = 3'd6,
    OP_WORD     = 3'd7
  } op_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [BITS_W-1:0]  bit_count;
    logic [COUNT_W-1:0] byte_length;
    logic [LADDR_W-1:0] load_address;
    logic [7:0]         load_value;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] delivered;
    logic               last;
  } result_t;

  typedef struct packed {
    op_t                op;
    logic [BITS_W-1:0]  bits;
    logic [COUNT_W-1:0] len;
    logic [BURST_W-1:0] burst;
    logic [LADDR_W-1:0] addr;
    logic [7:0]         wdata;
    logic               load_ok;
  } cmd_t;

endpackage

// ----- src/brd_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module brd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/brd_front.sv -----
// Front end: accepts input transactions and turns them into commands.
// Depends on brd_pkg; feeds the command queue.
module brd_front #(
  parameter int BUF_DEPTH = brd_pkg::DEFAULT_BUF_DEPTH,
  parameter int MAX_BITS  = brd_pkg::DEFAULT_MAX_BITS,
  parameter int MAX_BURST = brd_pkg::DEFAULT_MAX_BURST
) (
  input  logic           item_valid,
  output logic           item_ready,
  input  brd_pkg::item_t item,
  output logic           push,
  output brd_pkg::cmd_t  cmd,
  input  logic           full
);
  import brd_pkg::*;

  localparam logic [BITS_W-1:0]  BITS_CAP  = BITS_W'(MAX_BITS);
  localparam logic [BURST_W-1:0] BURST_CAP = BURST_W'(MAX_BURST);
  localparam int unsigned        DEPTH_U   = BUF_DEPTH;

  assign item_ready = !full;
  assign push       = item_valid && !full;

  always_comb begin
    cmd.op      = op_t'(item.operation);
    cmd.bits    = (item.bit_count > BITS_CAP) ? BITS_CAP : item.bit_count;
    cmd.len     = item.byte_length;
    cmd.burst   = (item.byte_length > COUNT_W'(BURST_CAP)) ? BURST_CAP
                                                            : item.byte_length[BURST_W-1:0];
    cmd.addr    = item.load_address;
    cmd.wdata   = item.load_value;
    // Loads aimed past the end of the buffer are dropped.
    cmd.load_ok = 32'(item.load_address) < DEPTH_U;
  end

endmodule

// ----- src/brd_queue.sv -----
// Two-entry command queue between the front end and the back end.
// Depends on brd_pkg for the command record.
module brd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  brd_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output brd_pkg::cmd_t dout,
  output logic          valid
);
  import brd_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign valid = count != 2'd0;
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

// ----- src/brd_back.sv -----
// Back end: executes commands against the byte buffer and the cursor,
// and holds the result register. Depends on brd_pkg and brd_ram.
module brd_back #(
  parameter int BUF_DEPTH = brd_pkg::DEFAULT_BUF_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [brd_pkg::COUNT_W-1:0]   byte_count,
  input  logic                          cmd_valid,
  input  brd_pkg::cmd_t                 cmd,
  output logic                          pop,
  output logic                          result_valid,
  input  logic                          result_ready,
  output brd_pkg::result_t              result
);
  import brd_pkg::*;

  localparam int          AW      = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int unsigned DEPTH_U = BUF_DEPTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BITS,
    ST_BYTES,
    ST_WORD,
    ST_PEEK
  } state_t;

  state_t               state, state_next;
  logic [CUR_W-1:0]     cursor, cursor_next;
  logic [2:0]           bitpos, bitpos_next;
  logic [BURST_W-1:0]   rem, rem_next;
  logic [COUNT_W-1:0]   total, total_next;
  logic [VALUE_W-1:0]   acc, acc_next;
  logic [BITS_W-1:0]    done, done_next;
  logic                 lsb, lsb_next;
  logic                 result_valid_next;
  result_t              result_next;

  logic                 out_free;
  logic                 emit;
  result_t              res_new;
  logic                 ram_we;
  logic [CUR_W-1:0]     raddr_full;
  logic [7:0]           rdata;

  logic [COUNT_W-1:0]   vb;
  logic [CUR_W-1:0]     ca;
  logic [COUNT_W-1:0]   left;
  logic [16:0]          pos;
  logic [16:0]          end_bits;
  logic [16:0]          avail;
  logic [BITS_W-1:0]    n_bits;
  logic [BURST_W-1:0]   n_read;
  logic [COUNT_W-1:0]   n_skip;
  logic [1:0]           n_word;
  logic                 peek_end;
  logic                 head_bits;

  logic [3:0]           bp1;
  logic [3:0]           k;
  logic                 byte_end;
  logic [7:0]           mask8;
  logic [7:0]           field;
  logic [VALUE_W-1:0]   acc_step;

  brd_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(cmd.addr)),
    .wdata(cmd.wdata),
    .raddr(AW'(raddr_full)),
    .rdata(rdata)
  );

  assign out_free = !result_valid || result_ready;

  // Geometry of the buffer seen from the current cursor.
  always_comb begin
    vb       = (32'(byte_count) > DEPTH_U) ? COUNT_W'(DEPTH_U) : byte_count;
    ca       = cursor + CUR_W'(bitpos != TOP_BIT);
    left     = ({1'b0, vb} > ca) ? COUNT_W'({1'b0, vb} - ca) : '0;
    pos      = {cursor, 3'b000} + 17'(TOP_BIT - bitpos);
    end_bits = {1'b0, vb, 3'b000};
    avail    = (end_bits > pos) ? end_bits - pos : '0;
    n_bits   = (17'(cmd.bits) < avail) ? cmd.bits : avail[BITS_W-1:0];
    n_read   = (COUNT_W'(cmd.burst) < left) ? cmd.burst : left[BURST_W-1:0];
    n_skip   = (cmd.len < left) ? cmd.len : left;
    n_word   = (left >= COUNT_W'(2)) ? 2'd2 : left[1:0];
    peek_end = ({1'b0, ca} + 15'd1) >= 15'(vb);
    head_bits = cmd.op == OP_BITS_MSB || cmd.op == OP_BITS_LSB;
  end

  // One byte's share of a bit read.
  always_comb begin
    bp1      = {1'b0, bitpos} + 4'd1;
    k        = ({3'b000, bp1} > rem) ? rem[3:0] : bp1;
    byte_end = k == bp1;
    mask8    = 8'((9'h001 << k) - 9'h001);
    if (lsb) begin
      field    = (rdata >> (TOP_BIT - bitpos)) & mask8;
      acc_step = acc | (VALUE_W'(field) << done);
    end else begin
      field    = (rdata >> (bp1 - k)) & mask8;
      acc_step = (acc << k) | VALUE_W'(field);
    end
  end

  always_comb begin
    state_next  = state;
    cursor_next = cursor;
    bitpos_next = bitpos;
    rem_next    = rem;
    total_next  = total;
    acc_next    = acc;
    done_next   = done;
    lsb_next    = lsb;
    pop         = 1'b0;
    ram_we      = 1'b0;
    emit        = 1'b0;
    res_new     = '{value: '0, delivered: '0, last: 1'b1};

    case (state)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          pop = 1'b1;
          case (cmd.op)
            OP_LOAD: begin
              ram_we = cmd.load_ok;
              emit   = 1'b1;
            end
            OP_REWIND: begin
              cursor_next = '0;
              bitpos_next = TOP_BIT;
              emit        = 1'b1;
            end
            OP_BITS_MSB, OP_BITS_LSB: begin
              if (n_bits == '0) begin
                emit = 1'b1;
              end else begin
                state_next = ST_BITS;
                rem_next   = BURST_W'(n_bits);
                total_next = COUNT_W'(n_bits);
                acc_next   = '0;
                done_next  = '0;
                lsb_next   = cmd.op == OP_BITS_LSB;
              end
            end
            OP_BYTES: begin
              cursor_next = ca;
              bitpos_next = TOP_BIT;
              if (n_read == '0) begin
                emit = 1'b1;
              end else begin
                state_next = ST_BYTES;
                rem_next   = n_read;
                total_next = COUNT_W'(n_read);
              end
            end
            OP_SKIP: begin
              cursor_next       = ca + CUR_W'(n_skip);
              bitpos_next       = TOP_BIT;
              emit              = 1'b1;
              res_new.delivered = n_skip;
            end
            OP_PEEK: begin
              if (peek_end) begin
                emit = 1'b1;
              end else begin
                state_next = ST_PEEK;
              end
            end
            OP_WORD: begin
              cursor_next = ca;
              bitpos_next = TOP_BIT;
              if (n_word == '0) begin
                emit = 1'b1;
              end else begin
                state_next = ST_WORD;
                rem_next   = BURST_W'(n_word);
                total_next = COUNT_W'(n_word);
                acc_next   = '0;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_BITS: begin
        if (rem != BURST_W'(k) || out_free) begin
          cursor_next = byte_end ? cursor + CUR_W'(1) : cursor;
          bitpos_next = byte_end ? TOP_BIT : bitpos - k[2:0];
          rem_next    = rem - BURST_W'(k);
          acc_next    = acc_step;
          done_next   = done + BITS_W'(k);
          if (rem == BURST_W'(k)) begin
            emit       = 1'b1;
            res_new    = '{value: acc_step, delivered: total, last: 1'b1};
            state_next = ST_IDLE;
          end
        end
      end
      ST_BYTES: begin
        if (out_free) begin
          cursor_next = cursor + CUR_W'(1);
          rem_next    = rem - BURST_W'(1);
          emit        = 1'b1;
          res_new     = '{value: VALUE_W'(rdata), delivered: total,
                          last: rem == BURST_W'(1)};
          if (rem == BURST_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_WORD: begin
        if (rem != BURST_W'(1) || out_free) begin
          cursor_next = cursor + CUR_W'(1);
          rem_next    = rem - BURST_W'(1);
          // The first byte of the word lands in the high half.
          acc_next    = acc | (VALUE_W'(rdata)
                               << ((COUNT_W'(rem) == total) ? 4'd8 : 4'd0));
          if (rem == BURST_W'(1)) begin
            emit       = 1'b1;
            res_new    = '{value: acc_next, delivered: total, last: 1'b1};
            state_next = ST_IDLE;
          end
        end
      end
      ST_PEEK: begin
        if (out_free) begin
          emit       = 1'b1;
          res_new    = '{value: VALUE_W'(rdata), delivered: '0, last: 1'b1};
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // The read port always points at the byte needed in the next cycle, so
    // a stalled step sees the same data again.
    if (state == ST_IDLE) begin
      raddr_full = head_bits ? cursor : ca;
    end else if (state == ST_PEEK) begin
      raddr_full = ca;
    end else begin
      raddr_full = cursor_next;
    end

    result_valid_next = emit || (result_valid && !result_ready);
    result_next       = emit ? res_new : result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cursor       <= '0;
      bitpos       <= TOP_BIT;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      cursor       <= cursor_next;
      bitpos       <= bitpos_next;
      result_valid <= result_valid_next;
    end
    rem    <= rem_next;
    total  <= total_next;
    acc    <= acc_next;
    done   <= done_next;
    lsb    <= lsb_next;
    result <= result_next;
  end

`ifndef SYNTH
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == ST_IDLE && out_free))
    else $error("command taken while the back end was busy");

  a_work_left: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BITS || state == ST_BYTES || state == ST_WORD) |-> rem != '0)
    else $error("multi-cycle command running with nothing left to do");

  a_rewind: assert property (@(posedge clk) disable iff (rst)
    (pop && cmd.op == OP_REWIND) |=> (cursor == '0 && bitpos == TOP_BIT))
    else $error("rewind did not return the cursor to the start");

  a_burst_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BYTES && out_free && rem == BURST_W'(1))
      |=> (state == ST_IDLE && result_valid && result.last))
    else $error("byte burst did not close with a last result");
`endif

endmodule

// ----- src/bitstream_reader.sv -----
// Bitstream reader top level: byte buffer read through a bit cursor.
// Load, rewind, skip and empty reads finish when the back end takes them;
// bit, word and peek reads step through each byte touched, one at a time,
// through the single byte-wide read port; a byte read gives one result a
// cycle while result_ready is high. Commands start only from idle.
// Reset clears the queue, sets the cursor to byte 0, bit 7 and byte_count to
// 0; buffer contents are undefined until loaded, with no clearing pass.
module bitstream_reader #(
  parameter int BUF_DEPTH = brd_pkg::DEFAULT_BUF_DEPTH,
  parameter int MAX_BITS  = brd_pkg::DEFAULT_MAX_BITS,
  parameter int MAX_BURST = brd_pkg::DEFAULT_MAX_BURST
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        count_write,
  input  logic [brd_pkg::COUNT_W-1:0] count_data,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  brd_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output brd_pkg::result_t            result
);
  import brd_pkg::*;

  logic [COUNT_W-1:0] byte_count;
  logic               push;
  logic               full;
  logic               pop;
  logic               head_valid;
  cmd_t               front_cmd;
  cmd_t               head_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (count_write) begin
      byte_count <= count_data;
    end
  end

  brd_front #(
    .BUF_DEPTH(BUF_DEPTH),
    .MAX_BITS (MAX_BITS),
    .MAX_BURST(MAX_BURST)
  ) u_front (
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .push      (push),
    .cmd       (front_cmd),
    .full      (full)
  );

  brd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (front_cmd),
    .full (full),
    .pop  (pop),
    .dout (head_cmd),
    .valid(head_valid)
  );

  brd_back #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .byte_count  (byte_count),
    .cmd_valid   (head_valid),
    .cmd         (head_cmd),
    .pop         (pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

// ----- dv/bitstream_reader_tb.sv -----
// Self-checking testbench for the bitstream_reader top level.
// Keeps a shadow buffer and bit cursor to predict every result transaction;
// depends only on brd_pkg and the bitstream_reader RTL.
module bitstream_reader_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brd_pkg::*;

  localparam int DEPTH       = DEFAULT_BUF_DEPTH;
  localparam int BIT_LIMIT   = DEFAULT_MAX_BITS;
  localparam int BURST_LIMIT = DEFAULT_MAX_BURST;
  localparam int STALL_LIMIT = 3000;
  localparam int MAX_REPORTS = 40;
  localparam int PHASE_ITEMS = 50;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               count_write  = 1'b0;
  logic [COUNT_W-1:0] count_data   = '0;
  logic               item_valid   = 1'b0;
  logic               item_ready;
  item_t              item         = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  result_t            result;

  bitstream_reader u_top (
    .clk          (clk),
    .rst          (rst),
    .count_write  (count_write),
    .count_data   (count_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  // Shadow of the buffer, cursor and byte_count register.
  logic [7:0] shadow_store [DEPTH];
  bit         shadow_written [DEPTH];
  int         shadow_byte  = 0;
  int         shadow_bit   = 7;
  int         shadow_count = 0;
  result_t    expected_reads [$];

  int error_count = 0;
  int idle_cycles = 0;
  int ready_hold  = 0;
  bit quiet_mode  = 1'b0;

  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int usable_bytes();
    return (shadow_count > DEPTH) ? DEPTH : shadow_count;
  endfunction

  function automatic int bytes_remaining();
    return (shadow_byte < usable_bytes()) ? usable_bytes() - shadow_byte : 0;
  endfunction

  function automatic logic [7:0] shadow_fetch(input int idx);
    return (idx < DEPTH) ? shadow_store[idx] : 8'h00;
  endfunction

  function automatic void align_shadow();
    if (shadow_bit != 7) begin
      shadow_bit = 7;
      shadow_byte++;
    end
  endfunction

  function automatic int bits_available();
    int pos;
    pos = shadow_byte * 8 + (7 - shadow_bit);
    return (usable_bytes() * 8 > pos) ? usable_bytes() * 8 - pos : 0;
  endfunction

  // Lowest buffer index that this item would read but no load has written yet.
  function automatic int first_unwritten(input item_t it);
    int lo, hi, start, left, want, n;
    lo = 0;
    hi = -1;
    start = shadow_byte + ((shadow_bit != 7) ? 1 : 0);
    left = (start < usable_bytes()) ? usable_bytes() - start : 0;
    case (op_t'(it.operation))
      OP_BITS_MSB, OP_BITS_LSB: begin
        want = (it.bit_count > BIT_LIMIT) ? BIT_LIMIT : it.bit_count;
        n = (want < bits_available()) ? want : bits_available();
        lo = shadow_byte;
        hi = (n > 0) ? (shadow_byte * 8 + (7 - shadow_bit) + n - 1) / 8 : -1;
      end
      OP_BYTES: begin
        want = (it.byte_length > BURST_LIMIT) ? BURST_LIMIT : it.byte_length;
        n = (want < left) ? want : left;
        lo = start;
        hi = start + n - 1;
      end
      OP_WORD: begin
        n = (left < 2) ? left : 2;
        lo = start;
        hi = start + n - 1;
      end
      OP_PEEK: begin
        if (start + 1 < usable_bytes()) begin
          lo = start;
          hi = start;
        end
      end
      default: ;
    endcase
    for (int i = lo; i <= hi; i++)
      if (!shadow_written[i]) return i;
    return -1;
  endfunction

  function automatic void push_expected(input logic [31:0] v, input int n, input logic l);
    result_t r;
    r.value     = v;
    r.delivered = COUNT_W'(n);
    r.last      = l;
    expected_reads.push_back(r);
  endfunction

  // Updates the shadow state for one accepted item and queues its results.
  function automatic void predict_reader_output(input item_t it);
    int          want, n, at;
    logic [31:0] acc;
    logic [7:0]  b;
    case (op_t'(it.operation))
      OP_LOAD: begin
        shadow_store[it.load_address]   = it.load_value;
        shadow_written[it.load_address] = 1'b1;
        push_expected('0, 0, 1'b1);
      end
      OP_REWIND: begin
        shadow_byte = 0;
        shadow_bit  = 7;
        push_expected('0, 0, 1'b1);
      end
      OP_BITS_MSB, OP_BITS_LSB: begin
        want = (it.bit_count > BIT_LIMIT) ? BIT_LIMIT : it.bit_count;
        n = (want < bits_available()) ? want : bits_available();
        acc = '0;
        for (int i = 0; i < n; i++) begin
          b = shadow_fetch(shadow_byte);
          if (it.operation == OP_BITS_LSB) acc[i] = b[7 - shadow_bit];
          else acc = {acc[30:0], b[shadow_bit]};
          if (shadow_bit == 0) begin
            shadow_bit = 7;
            shadow_byte++;
          end else begin
            shadow_bit--;
          end
        end
        push_expected(acc, n, 1'b1);
      end
      OP_BYTES: begin
        align_shadow();
        want = (it.byte_length > BURST_LIMIT) ? BURST_LIMIT : it.byte_length;
        n = bytes_remaining();
        if (want < n) n = want;
        if (n == 0) push_expected('0, 0, 1'b1);
        for (int i = 0; i < n; i++)
          push_expected({24'h0, shadow_fetch(shadow_byte + i)}, n, i == n - 1);
        shadow_byte += n;
      end
      OP_SKIP: begin
        align_shadow();
        n = bytes_remaining();
        if (it.byte_length < n) n = it.byte_length;
        shadow_byte += n;
        push_expected('0, n, 1'b1);
      end
      OP_PEEK: begin
        at = shadow_byte + ((shadow_bit == 7) ? 0 : 1);
        push_expected((at + 1 >= usable_bytes()) ? 32'h0 : {24'h0, shadow_fetch(at)},
                      0, 1'b1);
      end
      default: begin
        align_shadow();
        n = bytes_remaining();
        if (n > 2) n = 2;
        acc = '0;
        if (n >= 1) acc[15:8] = shadow_fetch(shadow_byte);
        if (n >= 2) acc[7:0] = shadow_fetch(shadow_byte + 1);
        shadow_byte += n;
        push_expected(acc, n, 1'b1);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_reads.size() == 0) begin
        report_mismatch("unexpected result transaction", result.value, '0);
      end else begin
        want = expected_reads.pop_front();
        if (result.value !== want.value) report_mismatch("value", result.value, want.value);
        if (result.delivered !== want.delivered)
          report_mismatch("delivered", result.delivered, want.delivered);
        if (result.last !== want.last) report_mismatch("last", result.last, want.last);
      end
    end
  end

  // Receiver back-pressure: mostly ready, with random short and long stalls.
  always @(negedge clk) begin
    if (ready_hold > 0) ready_hold--;
    else if ($urandom_range(0, 3) == 0) ready_hold = pick_gap();
    result_ready <= (ready_hold == 0);
  end

  always @(posedge clk) begin
    if (rst || count_write || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predict_reader_output(it);
  endtask

  // Loads any byte the item would read that was never written, then sends it.
  task automatic issue(input item_t it);
    int    hole;
    item_t fill;
    hole = first_unwritten(it);
    while (hole >= 0) begin
      fill = '0;
      fill.operation    = OP_LOAD;
      fill.load_address = LADDR_W'(hole);
      fill.load_value   = 8'($urandom);
      send_item(fill);
      hole = first_unwritten(it);
    end
    send_item(it);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    item_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    drop_valid();
    while (expected_reads.size() != 0) @(posedge clk);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] v);
    wait_drain();
    @(negedge clk);
    count_write <= 1'b1;
    count_data  <= v;
    @(negedge clk);
    count_write <= 1'b0;
    shadow_count = v;
  endtask

  function automatic item_t make_item(input op_t op, input int bits, input int len);
    item_t it;
    it = '0;
    it.operation   = op;
    it.bit_count   = BITS_W'(bits);
    it.byte_length = COUNT_W'(len);
    return it;
  endfunction

  function automatic item_t make_load(input int addr, input logic [7:0] val);
    item_t it;
    it = make_item(OP_LOAD, 0, 0);
    it.load_address = LADDR_W'(addr);
    it.load_value   = val;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t       it;
    logic [63:0] raw;
    int          r, span;
    raw = {$urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    r = $urandom_range(0, 99);
    if (r < 15)      it.operation = OP_LOAD;
    else if (r < 22) it.operation = OP_REWIND;
    else if (r < 40) it.operation = OP_BITS_MSB;
    else if (r < 58) it.operation = OP_BITS_LSB;
    else if (r < 70) it.operation = OP_BYTES;
    else if (r < 80) it.operation = OP_SKIP;
    else if (r < 90) it.operation = OP_PEEK;
    else             it.operation = OP_WORD;
    if ($urandom_range(0, 4) != 0) it.bit_count = BITS_W'($urandom_range(0, BIT_LIMIT));
    if ($urandom_range(0, 5) != 0) it.byte_length = COUNT_W'($urandom_range(0, 70));
    span = (usable_bytes() > 0) ? usable_bytes() : 1;
    if ($urandom_range(0, 3) != 0) it.load_address = LADDR_W'($urandom_range(0, span - 1));
    return it;
  endfunction

  // Every read against an empty buffer delivers nothing.
  task automatic test_empty_buffer();
    write_count('0);
    issue(make_load(12'hFFF, 8'hFF));
    issue(make_load(12'h000, 8'h00));
    issue(make_item(OP_BITS_MSB, 8, 0));
    issue(make_item(OP_BITS_LSB, 32, 0));
    issue(make_item(OP_BYTES, 0, 4));
    issue(make_item(OP_SKIP, 0, 3));
    issue(make_item(OP_PEEK, 0, 0));
    issue(make_item(OP_WORD, 0, 0));
  endtask

  task automatic test_directed_ops();
    logic [7:0] pattern [8] = '{8'hA5, 8'h3C, 8'hFF, 8'h00, 8'h81, 8'h7E, 8'h12, 8'h80};
    write_count(COUNT_W'(8));
    for (int i = 0; i < 8; i++) issue(make_load(i, pattern[i]));
    issue(make_item(OP_REWIND, 0, 0));
    issue(make_item(OP_BITS_MSB, 0, 0));
    issue(make_item(OP_BITS_MSB, 3, 0));
    issue(make_item(OP_PEEK, 0, 0));
    issue(make_item(OP_BITS_LSB, 13, 0));
    issue(make_item(OP_WORD, 0, 0));
    // Oversized bit count saturates and lands exactly on the end of the buffer.
    issue(make_item(OP_BITS_MSB, 63, 0));
    issue(make_item(OP_BITS_LSB, 5, 0));
    issue(make_item(OP_REWIND, 0, 0));
    issue(make_item(OP_BYTES, 0, 8191));
    issue(make_item(OP_BYTES, 0, 0));
    issue(make_item(OP_REWIND, 0, 0));
    issue(make_item(OP_SKIP, 0, 6));
    issue(make_item(OP_PEEK, 0, 0));
    issue(make_item(OP_SKIP, 0, 1));
    issue(make_item(OP_PEEK, 0, 0));
    issue(make_item(OP_WORD, 0, 0));
    issue(make_item(OP_WORD, 0, 0));
    issue(make_item(OP_SKIP, 0, 5));
    issue(make_item(OP_REWIND, 0, 0));
    issue(make_item(OP_BITS_MSB, 4, 0));
    issue(make_item(OP_BYTES, 0, 2));
  endtask

  // Full-depth buffer and a count above the depth, read near both ends.
  task automatic test_large_buffer();
    write_count(COUNT_W'(DEPTH));
    issue(make_item(OP_REWIND, 0, 0));
    issue(make_item(OP_BITS_LSB, 32, 0));
    issue(make_item(OP_SKIP, 0, 8191));
    issue(make_item(OP_PEEK, 0, 0));
    issue(make_item(OP_REWIND, 0, 0));
    issue(make_item(OP_SKIP, 0, DEPTH - 3));
    issue(make_item(OP_WORD, 0, 0));
    issue(make_item(OP_BYTES, 0, BURST_LIMIT));
    write_count(COUNT_W'(8191));
    issue(make_item(OP_REWIND, 0, 0));
    issue(make_item(OP_SKIP, 0, DEPTH - 2));
    issue(make_item(OP_BITS_MSB, 20, 0));
    issue(make_item(OP_REWIND, 0, 0));
    issue(make_item(OP_BYTES, 0, 100));
  endtask

  // Shrinking byte_count below the cursor leaves the cursor where it was.
  task automatic test_count_change();
    write_count(COUNT_W'(32));
    issue(make_item(OP_REWIND, 0, 0));
    issue(make_item(OP_SKIP, 0, 20));
    write_count(COUNT_W'(10));
    issue(make_item(OP_BITS_MSB, 8, 0));
    issue(make_item(OP_BYTES, 0, 3));
    issue(make_item(OP_PEEK, 0, 0));
    issue(make_item(OP_WORD, 0, 0));
    write_count(COUNT_W'(32));
    issue(make_item(OP_WORD, 0, 0));
    issue(make_item(OP_BITS_LSB, 12, 0));
  endtask

  task automatic test_random_phases();
    int cnt;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       cnt = $urandom_range(3, 64);
        1:       cnt = 1;
        2:       cnt = 2;
        3:       cnt = DEPTH;
        4:       cnt = 8191;
        5:       cnt = $urandom_range(0, 8191);
        default: cnt = $urandom_range(16, 300);
      endcase
      // The last phase runs back to back on both sides.
      quiet_mode = (ph == 6);
      write_count(COUNT_W'(cnt));
      issue(make_item(OP_REWIND, 0, 0));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 49) == 0) wait_drain();
        issue(random_item());
      end
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_empty_buffer();
    test_directed_ops();
    test_large_buffer();
    test_count_change();
    test_random_phases();
    wait_drain();
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_reads.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
